/* hw/rtl/gfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_pkg
// shared types and constants for the binary gnss frame receiver
// ----------------------------------------------------------------------------
package gfr_pkg;

	localparam logic [7:0] SYNC_FIRST      = 8'hB5;
	localparam logic [7:0] SYNC_SECOND     = 8'h62;
	localparam logic [7:0] ACK_CLASS_CODE  = 8'h05;
	localparam logic [7:0] ACK_ID_CODE     = 8'h01;
	localparam logic [7:0] NACK_ID_CODE    = 8'h00;
	localparam logic [15:0] ACK_PAYLOAD_LEN = 16'd2;

	localparam int IDX_W = 17;

	// position of the two payload bytes that an ack frame carries
	localparam logic [IDX_W-1:0] IDX_ACK_CLASS = 17'd4;
	localparam logic [IDX_W-1:0] IDX_ACK_ID    = 17'd5;
	// payload ends at index length + 3
	localparam logic [IDX_W-1:0] IDX_HDR_LAST  = 17'd3;

	typedef enum logic [3:0] {
		PH_HUNT1   = 4'd0,
		PH_HUNT2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_IDENT   = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CK_A    = 4'd7,
		PH_CK_B    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_NACK  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last_of_frame;
		logic             checksum_ok;
		kind_t            frame_kind;
		logic [7:0]       ack_class;
		logic [7:0]       ack_id;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/gfr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_parser
// frame state, running fletcher sums and per-byte result logic
// ----------------------------------------------------------------------------
module gfr_parser import gfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	output result_t         res
);

	phase_t           phase_q, phase_nxt;
	logic [IDX_W-1:0] count_q, count_nxt;
	logic [15:0]      len_q, len_nxt;
	logic [7:0]       sum_a_q, sum_a_nxt;
	logic [7:0]       sum_b_q, sum_b_nxt;
	logic             ck_a_ok_q, ck_a_ok_nxt;
	logic [7:0]       cls_q, cls_nxt;
	logic [7:0]       ident_q, ident_nxt;
	logic [7:0]       hold_cls_q, hold_cls_nxt;
	logic [7:0]       hold_id_q, hold_id_nxt;
	logic [7:0]       add_a;
	logic [7:0]       add_b;
	logic [15:0]      len_full;
	logic [IDX_W-1:0] pay_end;

	assign add_a    = sum_a_q + rx_byte;
	assign add_b    = sum_b_q + add_a;
	assign len_full = {rx_byte, len_q[7:0]};
	assign pay_end  = {1'b0, len_q} + IDX_HDR_LAST;

	always_comb begin
		phase_nxt    = phase_q;
		count_nxt    = count_q;
		len_nxt      = len_q;
		sum_a_nxt    = sum_a_q;
		sum_b_nxt    = sum_b_q;
		ck_a_ok_nxt  = ck_a_ok_q;
		cls_nxt      = cls_q;
		ident_nxt    = ident_q;
		hold_cls_nxt = hold_cls_q;
		hold_id_nxt  = hold_id_q;
		res_valid    = 1'b1;
		res.data_byte     = rx_byte;
		res.byte_index    = count_q;
		res.last_of_frame = 1'b0;
		res.checksum_ok   = 1'b0;
		res.frame_kind    = KIND_OTHER;
		res.ack_class     = 8'd0;
		res.ack_id        = 8'd0;
		unique case (phase_q)
			PH_HUNT1: begin
				res_valid = 1'b0;
				if (rx_byte == SYNC_FIRST) begin
					phase_nxt = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				res_valid = 1'b0;
				if (rx_byte == SYNC_SECOND) begin
					phase_nxt    = PH_CLASS;
					count_nxt    = '0;
					len_nxt      = '0;
					sum_a_nxt    = '0;
					sum_b_nxt    = '0;
					ck_a_ok_nxt  = 1'b0;
					cls_nxt      = '0;
					ident_nxt    = '0;
					hold_cls_nxt = '0;
					hold_id_nxt  = '0;
				end else begin
					phase_nxt = PH_HUNT1;
				end
			end
			PH_CLASS: begin
				cls_nxt   = rx_byte;
				sum_a_nxt = add_a;
				sum_b_nxt = add_b;
				phase_nxt = PH_IDENT;
			end
			PH_IDENT: begin
				ident_nxt = rx_byte;
				sum_a_nxt = add_a;
				sum_b_nxt = add_b;
				phase_nxt = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_nxt   = {8'd0, rx_byte};
				sum_a_nxt = add_a;
				sum_b_nxt = add_b;
				phase_nxt = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_nxt   = len_full;
				sum_a_nxt = add_a;
				sum_b_nxt = add_b;
				phase_nxt = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (count_q == IDX_ACK_CLASS) begin
					hold_cls_nxt = rx_byte;
				end else if (count_q == IDX_ACK_ID) begin
					hold_id_nxt = rx_byte;
				end
				sum_a_nxt = add_a;
				sum_b_nxt = add_b;
				if (count_q >= pay_end) begin
					phase_nxt = PH_CK_A;
				end
			end
			PH_CK_A: begin
				ck_a_ok_nxt = (rx_byte == sum_a_q);
				phase_nxt   = PH_CK_B;
			end
			PH_CK_B: begin
				res.last_of_frame = 1'b1;
				res.checksum_ok   = ck_a_ok_q && (rx_byte == sum_b_q);
				if (cls_q == ACK_CLASS_CODE && len_q == ACK_PAYLOAD_LEN) begin
					if (ident_q == ACK_ID_CODE) begin
						res.frame_kind = KIND_ACK;
					end else if (ident_q == NACK_ID_CODE) begin
						res.frame_kind = KIND_NACK;
					end
				end
				if (res.frame_kind != KIND_OTHER) begin
					res.ack_class = hold_cls_q;
					res.ack_id    = hold_id_q;
				end
				phase_nxt = PH_HUNT1;
			end
			default: begin
				res_valid = 1'b0;
				phase_nxt = PH_HUNT1;
			end
		endcase
		if (res_valid) begin
			count_nxt = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT1;
			count_q    <= '0;
			len_q      <= '0;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			ck_a_ok_q  <= 1'b0;
			cls_q      <= '0;
			ident_q    <= '0;
			hold_cls_q <= '0;
			hold_id_q  <= '0;
		end else if (take) begin
			phase_q    <= phase_nxt;
			count_q    <= count_nxt;
			len_q      <= len_nxt;
			sum_a_q    <= sum_a_nxt;
			sum_b_q    <= sum_b_nxt;
			ck_a_ok_q  <= ck_a_ok_nxt;
			cls_q      <= cls_nxt;
			ident_q    <= ident_nxt;
			hold_cls_q <= hold_cls_nxt;
			hold_id_q  <= hold_id_nxt;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/gfr_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_out_stage
// result register with valid/ready, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module gfr_out_stage import gfr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t load_res,
	output logic         room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			res_q <= load_res;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/binary_gnss_frame_receiver.sv */
`default_nettype none
// a frame byte shows on the output in the cycle after its input transaction
// throughput: one byte per cycle; in_ready drops only while a result waits on out_ready
// sync bytes and bytes seen while hunting give no output transaction
// reset (arst_n low, asynchronous): parser hunts for the first sync byte, output empty
// ----------------------------------------------------------------------------
// binary_gnss_frame_receiver
// sync hunt, header/payload walk and fletcher check for binary gnss frames
// ----------------------------------------------------------------------------
module binary_gnss_frame_receiver import gfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	// frame byte output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic [16:0]      byte_index,
	output logic             last_of_frame,
	output logic             checksum_ok,
	output logic [1:0]       frame_kind,
	output logic [7:0]       ack_class,
	output logic [7:0]       ack_id
);

	logic    take;
	logic    room;
	logic    res_valid;
	result_t res;
	result_t out_res;

	// a byte is taken whenever the result register can take its result
	assign in_ready = room;
	assign take     = in_valid && room;

	// parser state steps once per input transaction
	gfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// only bytes from the class byte onward produce a result
	gfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && res_valid),
		.load_res  (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_byte     = out_res.data_byte;
	assign byte_index    = out_res.byte_index;
	assign last_of_frame = out_res.last_of_frame;
	assign checksum_ok   = out_res.checksum_ok;
	assign frame_kind    = out_res.frame_kind;
	assign ack_class     = out_res.ack_class;
	assign ack_id        = out_res.ack_id;

`ifndef SYNTHESIS
	// check and kind are only reported on the closing checksum byte
	a_flags_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> !checksum_ok && frame_kind == KIND_OTHER)
		else $error("check or kind flagged before end of frame");

	// acknowledged class and id only accompany an ack or nack
	a_ack_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == KIND_OTHER |-> ack_class == 8'd0 && ack_id == 8'd0)
		else $error("ack fields set on a non-ack frame");

	// shortest frame: class, id, two length bytes, two checksum bytes
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> byte_index >= 17'd5)
		else $error("frame closed too early");
`endif

endmodule
`default_nettype wire
